/* design/laser_line_corner_detector_top_macros.svh */
// assertion macros for the laser line corner detector checker
`ifndef LASER_LINE_CORNER_DETECTOR_TOP_MACROS_SVH
`define LASER_LINE_CORNER_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define LLCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LLCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/llcd_pkg.sv */
// shared types, constants and tables of the laser line corner detector
package llcd_pkg;

  localparam int unsigned LenW   = 17;
  localparam int unsigned CntW   = 10;
  localparam int unsigned NrmW   = 16;
  localparam int unsigned OffW   = 18;
  localparam int unsigned BndW   = 15;
  localparam int unsigned RngW   = 18;
  localparam int unsigned BrgW   = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 17;

  localparam int unsigned MulW   = 21;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned DotW   = 33;
  localparam int unsigned NumW   = 35;
  localparam int unsigned QuoW   = 20;
  localparam int unsigned DivNW  = 34;
  localparam int unsigned DivDW  = 32;
  localparam int unsigned SqrtVW = 42;
  localparam int unsigned RootW  = 21;
  localparam int unsigned CrdInW = 36;
  localparam int unsigned CrdW   = 38;
  localparam int unsigned AngW   = 18;
  localparam int unsigned CrdSteps = 16;

  localparam logic [RngW-1:0] RangeMax = '1;

  localparam logic [LenW-1:0] MinLenRst  = 17'd1000;
  localparam logic [BndW-1:0] PerpBndRst = 15'd3277;
  localparam logic [BndW-1:0] GndBndRst  = 15'd1638;
  localparam logic [CntW-1:0] MaxPtsRst  = 10'd20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_LEN  = 3'd0,
    CFG_PERP_BND = 3'd1,
    CFG_GND_BND  = 3'd2,
    CFG_MAX_PTS  = 3'd3,
    CFG_REJ_GND  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_DIVX,
    ST_DIVY,
    ST_SQ,
    ST_SQRT,
    ST_CORDIC,
    ST_DONE
  } llcd_state_e;

  // start strobes from the sequencer to the iterative units
  typedef struct packed {
    logic div;
    logic sqrt;
    logic cordic;
  } unit_start_t;

  // rounded arctangent table, 8192 is a quarter of pi
  function automatic logic [13:0] atan_tab(input logic [3:0] idx);
    logic [13:0] v;
    unique case (idx)
      4'd0:  v = 14'd8192;
      4'd1:  v = 14'd4836;
      4'd2:  v = 14'd2555;
      4'd3:  v = 14'd1297;
      4'd4:  v = 14'd651;
      4'd5:  v = 14'd326;
      4'd6:  v = 14'd163;
      4'd7:  v = 14'd81;
      4'd8:  v = 14'd41;
      4'd9:  v = 14'd20;
      4'd10: v = 14'd10;
      4'd11: v = 14'd5;
      4'd12: v = 14'd3;
      4'd13: v = 14'd1;
      4'd14: v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/llcd_mul.sv */
// shared signed multiplier with registered product
module llcd_mul
  import llcd_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [MulW-1:0]  a_i,
  input  logic signed [MulW-1:0]  b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

/* design/llcd_div.sv */
// restoring divider, one quotient bit per cycle, for num * 2^16 / den
module llcd_div
  import llcd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [DivDW-1:0] den_i,
  output logic             done_o,
  output logic [QuoW-1:0]  quo_o,
  output logic             ovf_o
);

  logic [DivDW-1:0] rem_q, den_q;
  logic [QuoW-1:0]  sh_q, quo_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q, ovf_q;
  logic [DivDW:0]   trial;
  logic             fits;

  assign trial = {rem_q, sh_q[QuoW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(QuoW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= DivDW'(num_i >> 4);
      sh_q  <= {num_i[3:0], 16'd0};
      quo_q <= '0;
      ovf_q <= {2'b00, num_i} >= {den_i, 4'd0};
    end else if (busy_q) begin
      rem_q <= fits ? DivDW'(trial - {1'b0, den_q}) : DivDW'(trial);
      sh_q  <= {sh_q[QuoW-2:0], 1'b0};
      quo_q <= {quo_q[QuoW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign ovf_o  = ovf_q;

endmodule

/* design/llcd_isqrt.sv */
// bit-pair integer square root, rounds down, one step per cycle
module llcd_isqrt
  import llcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SqrtVW-1:0] val_i,
  output logic              done_o,
  output logic [RootW-1:0]  root_o
);

  logic [SqrtVW-1:0] v_q, r_q, bit_q, t;
  logic              busy_q, done_q;

  assign t = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= SqrtVW'(1) << (SqrtVW - 2);
    end else if (busy_q) begin
      if (v_q >= t) begin
        v_q <= v_q - t;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[RootW-1:0];

endmodule

/* design/llcd_cordic.sv */
// vectoring cordic, quarter-turn prestep then one rotation per cycle
module llcd_cordic
  import llcd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CrdInW-1:0] x_i,
  input  logic signed [CrdInW-1:0] y_i,
  output logic                     done_o,
  output logic signed [AngW-1:0]   ang_o
);

  logic signed [CrdW-1:0] x_q, y_q, xs, ys, xe, ye;
  logic signed [AngW-1:0] z_q, tab;
  logic [3:0]             i_q;
  logic                   busy_q, done_q;

  assign xe  = CrdW'(x_i);
  assign ye  = CrdW'(y_i);
  assign xs  = x_q >>> i_q;
  assign ys  = y_q >>> i_q;
  assign tab = $signed(AngW'(atan_tab(i_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 4'd1;
        if (i_q == 4'(CrdSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (!xe[CrdW-1]) begin
        x_q <= xe;
        y_q <= ye;
        z_q <= '0;
      end else if (!ye[CrdW-1]) begin
        x_q <= ye;
        y_q <= -xe;
        z_q <= AngW'(16384);
      end else begin
        x_q <= -ye;
        y_q <= xe;
        z_q <= -AngW'(16384);
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - tab;
      end
    end
  end

  assign done_o = done_q;
  assign ang_o  = z_q;

endmodule

/* design/laser_line_corner_detector_top.sv */
// laser line corner detector: sequencer, held section and shared arithmetic units
// an unpaired request goes from idle straight to done; a pair that fails the check stops after
//   the multiply and check states; a corner runs multiply, check, divide, square, square root, cordic, done
// far corners skip the square and square root; the sequencer returns to idle before the next request
// throughput: one request at a time, in_ready_o is high only in the idle state
// reset: asynchronous active low, clears the held section and loads register defaults
module laser_line_corner_detector_top
  import llcd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDatW-1:0]  cfg_data_i,
  // section request
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                first_in_scan_i,
  input  logic                is_line_i,
  input  logic                connects_next_i,
  input  logic [LenW-1:0]     line_length_i,
  input  logic [CntW-1:0]     point_count_i,
  input  logic signed [NrmW-1:0] normal_x_i,
  input  logic signed [NrmW-1:0] normal_y_i,
  input  logic signed [OffW-1:0] line_offset_i,
  // corner result
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RngW-1:0]     corner_range_o,
  output logic signed [BrgW-1:0] corner_bearing_o,
  output logic                possible_ground_o
);

  // configuration registers
  logic [LenW-1:0] min_len_q;
  logic [BndW-1:0] perp_bnd_q, gnd_bnd_q;
  logic [CntW-1:0] max_pts_q;
  logic            rej_gnd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q  <= MinLenRst;
      perp_bnd_q <= PerpBndRst;
      gnd_bnd_q  <= GndBndRst;
      max_pts_q  <= MaxPtsRst;
      rej_gnd_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_LEN:  min_len_q  <= cfg_data_i[LenW-1:0];
        CFG_PERP_BND: perp_bnd_q <= cfg_data_i[BndW-1:0];
        CFG_GND_BND:  gnd_bnd_q  <= cfg_data_i[BndW-1:0];
        CFG_MAX_PTS:  max_pts_q  <= cfg_data_i[CntW-1:0];
        CFG_REJ_GND:  rej_gnd_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // held (previous) section and current section
  logic                   held_valid_q, held_line_q, held_conn_q;
  logic [LenW-1:0]        held_len_q;
  logic [CntW-1:0]        held_cnt_q;
  logic signed [NrmW-1:0] held_a_q, held_b_q;
  logic signed [OffW-1:0] held_c_q;

  logic                   cur_line_q, cur_conn_q;
  logic [LenW-1:0]        cur_len_q;
  logic [CntW-1:0]        cur_cnt_q;
  logic signed [NrmW-1:0] cur_a_q, cur_b_q;
  logic signed [OffW-1:0] cur_c_q;

  llcd_state_e state_q, state_d;
  logic [3:0]  cnt_q;
  unit_start_t start;

  logic in_acc, pair_ok;
  assign in_acc = in_valid_i && in_ready_o;

  // pairing rule on the held section and the arriving one
  assign pair_ok = held_valid_q && !first_in_scan_i && held_line_q && held_conn_q &&
                   is_line_i && (held_len_q >= min_len_q) && (line_length_i >= min_len_q);

  // shared multiplier
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;

  llcd_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  logic [QuoW-1:0] qx_q, qy_q;

  // operand schedule: dot, determinant, then the two numerators, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_MUL) begin
      unique case (cnt_q)
        4'd0: begin mul_a = MulW'(held_a_q); mul_b = MulW'(cur_a_q); end
        4'd1: begin mul_a = MulW'(held_b_q); mul_b = MulW'(cur_b_q); end
        4'd2: begin mul_a = MulW'(held_b_q); mul_b = MulW'(cur_a_q); end
        4'd3: begin mul_a = MulW'(cur_b_q);  mul_b = MulW'(held_a_q); end
        4'd4: begin mul_a = MulW'(cur_b_q);  mul_b = MulW'(held_c_q); end
        4'd5: begin mul_a = MulW'(held_b_q); mul_b = MulW'(cur_c_q); end
        4'd6: begin mul_a = MulW'(held_a_q); mul_b = MulW'(cur_c_q); end
        4'd7: begin mul_a = MulW'(cur_a_q);  mul_b = MulW'(held_c_q); end
        default: ;
      endcase
    end else if (state_q == ST_SQ) begin
      if (cnt_q == 4'd0) begin
        mul_a = $signed({1'b0, qx_q});
        mul_b = $signed({1'b0, qx_q});
      end else begin
        mul_a = $signed({1'b0, qy_q});
        mul_b = $signed({1'b0, qy_q});
      end
    end
  end

  // accumulated terms
  logic signed [DotW-1:0] dot_q, den_q;
  logic signed [NumW-1:0] nx_q, ny_q;
  logic [SqrtVW-1:0]      sum_q;

  logic [DotW-1:0]   adot;
  logic [DivNW-1:0]  anx, any;
  logic [DivDW-1:0]  aden;
  logic              check_ok, gnd_calc;

  assign adot = dot_q[DotW-1] ? DotW'(-dot_q) : DotW'(dot_q);
  assign anx  = nx_q[NumW-1] ? DivNW'(-nx_q) : DivNW'(nx_q);
  assign any  = ny_q[NumW-1] ? DivNW'(-ny_q) : DivNW'(ny_q);
  assign aden = den_q[DotW-1] ? DivDW'(-den_q) : DivDW'(den_q);
  assign check_ok = (adot < {4'd0, perp_bnd_q, 14'd0}) && (den_q != '0);

  // flat line with many points may be ground
  logic [NrmW-1:0] habs_b, cabs_b;
  assign habs_b = held_b_q[NrmW-1] ? NrmW'(-held_b_q) : NrmW'(held_b_q);
  assign cabs_b = cur_b_q[NrmW-1] ? NrmW'(-cur_b_q) : NrmW'(cur_b_q);
  assign gnd_calc = rej_gnd_q &&
                    (((held_cnt_q > max_pts_q) && (habs_b < {1'b0, gnd_bnd_q})) ||
                     ((cur_cnt_q > max_pts_q) && (cabs_b < {1'b0, gnd_bnd_q})));

  // divider, used for x then y
  logic            div_done, div_ovf;
  logic [QuoW-1:0] div_quo;

  llcd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start.div),
    .num_i  ((state_q == ST_CHECK) ? anx : any),
    .den_i  (aden),
    .done_o (div_done),
    .quo_o  (div_quo),
    .ovf_o  (div_ovf)
  );

  // square root of x^2 + y^2 in quarter mm
  logic             sqrt_done;
  logic [RootW-1:0] root;

  llcd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start.sqrt),
    .val_i  (sum_q),
    .done_o (sqrt_done),
    .root_o (root)
  );

  logic [RootW:0]  rnd;
  logic [RngW-1:0] rng_calc;
  assign rnd      = {1'b0, root} + (RootW+1)'(2);
  assign rng_calc = (rnd[RootW:2] > {2'b00, RangeMax}) ? RangeMax : rnd[RngW+1:2];

  // bearing from the sign-corrected numerators
  logic signed [CrdInW-1:0] crd_x, crd_y;
  logic                     crd_done;
  logic signed [AngW-1:0]   ang;

  assign crd_x = den_q[DotW-1] ? -CrdInW'(nx_q) : CrdInW'(nx_q);
  assign crd_y = den_q[DotW-1] ? -CrdInW'(ny_q) : CrdInW'(ny_q);

  llcd_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start.cordic),
    .x_i    (crd_x),
    .y_i    (crd_y),
    .done_o (crd_done),
    .ang_o  (ang)
  );

  logic ovf_q, has_res_q, gnd_q;
  logic [RngW-1:0] rng_q;
  logic signed [BrgW-1:0] brg_q;
  logic out_valid_q;
  logic [RngW-1:0] out_rng_q;
  logic signed [BrgW-1:0] out_brg_q;
  logic out_gnd_q;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = pair_ok ? ST_MUL : ST_DONE;
      ST_MUL:    if (cnt_q == 4'd8) state_d = ST_CHECK;
      ST_CHECK:  state_d = check_ok ? ST_DIVX : ST_DONE;
      ST_DIVX:   if (div_done) state_d = ST_DIVY;
      ST_DIVY:   if (div_done) state_d = (ovf_q || div_ovf) ? ST_CORDIC : ST_SQ;
      ST_SQ:     if (cnt_q == 4'd3) state_d = ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_d = (rng_calc != '0) ? ST_CORDIC : ST_DONE;
      ST_CORDIC: if (crd_done) state_d = ST_DONE;
      ST_DONE:   if (!has_res_q || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // unit start strobes and handshake outputs
  always_comb begin
    start.div    = ((state_q == ST_CHECK) && check_ok) || ((state_q == ST_DIVX) && div_done);
    // sum of squares is complete once the second product has been added
    start.sqrt   = (state_q == ST_SQ) && (cnt_q == 4'd3);
    start.cordic = ((state_q == ST_DIVY) && div_done && (ovf_q || div_ovf)) ||
                   ((state_q == ST_SQRT) && sqrt_done && (rng_calc != '0));
    in_ready_o   = (state_q == ST_IDLE);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      held_valid_q <= 1'b0;
      held_line_q  <= 1'b0;
      held_conn_q  <= 1'b0;
      held_len_q   <= '0;
      held_cnt_q   <= '0;
      held_a_q     <= '0;
      held_b_q     <= '0;
      held_c_q     <= '0;
      has_res_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= '0;
      else cnt_q <= cnt_q + 4'd1;
      if (in_acc) has_res_q <= 1'b0;
      if (state_q == ST_CHECK && check_ok) has_res_q <= 1'b1;
      if (state_q == ST_DONE && state_d == ST_IDLE) begin
        // current section becomes the held one
        held_valid_q <= 1'b1;
        held_line_q  <= cur_line_q;
        held_conn_q  <= cur_conn_q;
        held_len_q   <= cur_len_q;
        held_cnt_q   <= cur_cnt_q;
        held_a_q     <= cur_a_q;
        held_b_q     <= cur_b_q;
        held_c_q     <= cur_c_q;
      end
      if (state_q == ST_DONE && state_d == ST_IDLE && has_res_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_line_q <= is_line_i;
      cur_conn_q <= connects_next_i;
      cur_len_q  <= line_length_i;
      cur_cnt_q  <= point_count_i;
      cur_a_q    <= normal_x_i;
      cur_b_q    <= normal_y_i;
      cur_c_q    <= line_offset_i;
    end
    if (state_q == ST_MUL) begin
      unique case (cnt_q)
        4'd1: dot_q <= DotW'(prod);
        4'd2: dot_q <= dot_q + DotW'(prod);
        4'd3: den_q <= DotW'(prod);
        4'd4: den_q <= den_q - DotW'(prod);
        4'd5: nx_q  <= NumW'(prod);
        4'd6: nx_q  <= nx_q - NumW'(prod);
        4'd7: ny_q  <= NumW'(prod);
        4'd8: ny_q  <= ny_q - NumW'(prod);
        default: ;
      endcase
    end
    if (state_q == ST_CHECK) begin
      gnd_q <= gnd_calc;
      ovf_q <= 1'b0;
      brg_q <= '0;
    end
    if (state_q == ST_DIVX && div_done) begin
      qx_q  <= div_quo;
      ovf_q <= div_ovf;
    end
    if (state_q == ST_DIVY && div_done) begin
      qy_q <= div_quo;
      if (ovf_q || div_ovf) rng_q <= RangeMax;
    end
    if (state_q == ST_SQ) begin
      if (cnt_q == 4'd1) sum_q <= SqrtVW'(unsigned'(prod));
      if (cnt_q == 4'd2) sum_q <= sum_q + SqrtVW'(unsigned'(prod));
    end
    if (state_q == ST_SQRT && sqrt_done) rng_q <= rng_calc;
    if (state_q == ST_CORDIC && crd_done) brg_q <= ang[BrgW-1:0];
    if (state_q == ST_DONE && has_res_q && out_free) begin
      out_rng_q <= rng_q;
      out_brg_q <= brg_q;
      out_gnd_q <= gnd_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign corner_range_o    = out_rng_q;
  assign corner_bearing_o  = out_brg_q;
  assign possible_ground_o = out_gnd_q;

endmodule

/* design/llcd_checker.sv */
// port-level checks of the corner detector, bound to the top level
`include "laser_line_corner_detector_top_macros.svh"

module llcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [17:0] corner_range_o,
  input logic [15:0] corner_bearing_o,
  input logic        possible_ground_o
);

  `LLCD_ASSERT_NXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "ready after request")
  `LLCD_ASSERT_NOW(a_new_res_busy, $rose(out_valid_o), $past(!in_ready_o), "result while idle")
  `LLCD_ASSERT_NOW(a_zero_range, out_valid_o && corner_range_o == 18'd0, corner_bearing_o == 16'd0, "bearing at zero range")
  `LLCD_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `LLCD_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(corner_range_o) && $stable(corner_bearing_o) && $stable(possible_ground_o), "result changed")

endmodule

bind laser_line_corner_detector_top llcd_checker u_llcd_checker (.*);
